// ----- rtl/core/bfa_pkg.sv -----
// Package for the bitmap first-fit block allocator.
// Holds the sizes, codes, state and control types, and bitmap helper functions.
// Has no dependencies.
package bfa_pkg;

  localparam int MAX_BLOCKS = 4096;
  localparam int WORD_BITS  = 64;
  localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int BLK_W      = 12;
  localparam int LIMIT_W    = 13;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int WORD_AW    = $clog2(MAP_WORDS);
  localparam int WORDS_W    = $clog2(MAP_WORDS + 1);
  localparam logic [LIMIT_W-1:0]   TOTAL_RESET = LIMIT_W'(512);
  localparam logic [WORD_BITS-1:0] WORD0_RESET = WORD_BITS'(3);

  typedef enum logic [1:0] {
    OP_FORMAT = 2'd0,
    OP_ALLOC  = 2'd1,
    OP_FREE   = 2'd2,
    OP_MARK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PS_OK,
    PS_FULL,
    PS_RANGE,
    PS_ALLOC
  } pend_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SCAN,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic      load;
    logic      clear_map;
    logic      scan_start;
    logic      scan_step;
    logic      rmw_read;
    logic      rmw_write;
    logic      pend_we;
    pend_sel_t pend_sel;
    logic      out_load;
    logic      cfg_we;
  } dp_cmd_t;

  typedef struct packed {
    op_t  op;
    logic range_bad;
    logic words_zero;
    logic hit;
    logic scan_end;
  } dp_sts_t;

  function automatic logic [BIT_W-1:0] first_zero(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        idx = BIT_W'(i);
      end
    end
    return idx;
  endfunction

  function automatic logic [WORD_BITS-1:0] reset_word(input logic [WORD_AW-1:0] a);
    logic [WORD_BITS-1:0] w;
    w = (a == '0) ? WORD0_RESET : '0;
    return w;
  endfunction

endpackage

// ----- rtl/core/bfa_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
// Has no dependencies.
module bfa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/bfa_ctrl.sv -----
// Controller state machine of the block allocator.
// Depends on bfa_pkg; drives datapath commands and reads datapath status.
module bfa_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  output bfa_pkg::dp_cmd_t cmd,
  input  bfa_pkg::dp_sts_t sts
);

  bfa_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = bfa_pkg::ST_DISPATCH;
        end
      end
      bfa_pkg::ST_DISPATCH: begin
        case (sts.op)
          bfa_pkg::OP_FORMAT: state_nxt = bfa_pkg::ST_FIN;
          bfa_pkg::OP_ALLOC: begin
            state_nxt = sts.words_zero ? bfa_pkg::ST_FIN : bfa_pkg::ST_SCAN;
          end
          default: begin
            state_nxt = sts.range_bad ? bfa_pkg::ST_FIN : bfa_pkg::ST_RMW_RD;
          end
        endcase
      end
      bfa_pkg::ST_SCAN: begin
        if (sts.hit || sts.scan_end) begin
          state_nxt = bfa_pkg::ST_FIN;
        end
      end
      bfa_pkg::ST_RMW_RD: state_nxt = bfa_pkg::ST_RMW_WR;
      bfa_pkg::ST_RMW_WR: state_nxt = bfa_pkg::ST_FIN;
      bfa_pkg::ST_FIN: begin
        if (out_free) begin
          state_nxt = bfa_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.pend_sel = bfa_pkg::PS_OK;
    in_stall     = (state_r != bfa_pkg::ST_IDLE);
    cfg_ready    = (state_r == bfa_pkg::ST_IDLE);
    cmd.cfg_we   = cfg_valid && (state_r == bfa_pkg::ST_IDLE);
    case (state_r)
      bfa_pkg::ST_IDLE: begin
        cmd.load = in_valid;
      end
      bfa_pkg::ST_DISPATCH: begin
        case (sts.op)
          bfa_pkg::OP_FORMAT: begin
            cmd.clear_map = 1'b1;
            cmd.pend_we   = 1'b1;
            cmd.pend_sel  = bfa_pkg::PS_OK;
          end
          bfa_pkg::OP_ALLOC: begin
            cmd.scan_start = !sts.words_zero;
            cmd.pend_we    = sts.words_zero;
            cmd.pend_sel   = bfa_pkg::PS_FULL;
          end
          default: begin
            cmd.pend_we  = sts.range_bad;
            cmd.pend_sel = bfa_pkg::PS_RANGE;
          end
        endcase
      end
      bfa_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.pend_we   = sts.hit || sts.scan_end;
        cmd.pend_sel  = sts.hit ? bfa_pkg::PS_ALLOC : bfa_pkg::PS_FULL;
      end
      bfa_pkg::ST_RMW_RD: begin
        cmd.rmw_read = 1'b1;
      end
      bfa_pkg::ST_RMW_WR: begin
        cmd.rmw_write = 1'b1;
        cmd.pend_we   = 1'b1;
        cmd.pend_sel  = bfa_pkg::PS_OK;
      end
      bfa_pkg::ST_FIN: begin
        cmd.out_load = out_free;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/core/bfa_dp.sv -----
// Datapath of the block allocator: item and limit registers, bitmap RAM with
// per-word valid bits, word scan pointer, bit update logic and result registers.
// Depends on bfa_pkg and bfa_ram.
module bfa_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [1:0]                     in_command,
  input  logic [bfa_pkg::BLK_W-1:0]      in_block_index,
  input  logic [bfa_pkg::LIMIT_W-1:0]    cfg_total_blocks,
  output logic [bfa_pkg::BLK_W-1:0]      out_result_block,
  output logic [1:0]                     out_status,
  input  bfa_pkg::dp_cmd_t               cmd,
  output bfa_pkg::dp_sts_t               sts
);

  bfa_pkg::op_t                     op_r;
  logic [bfa_pkg::BLK_W-1:0]        blk_r;
  logic [bfa_pkg::LIMIT_W-1:0]      total_r;
  logic [bfa_pkg::WORDS_W-1:0]      ptr_r;
  logic [bfa_pkg::WORD_AW-1:0]      cur_r;
  logic                             chk_vld_r;
  logic [bfa_pkg::MAP_WORDS-1:0]    valid_r;
  logic [bfa_pkg::BLK_W-1:0]        pend_block_r;
  bfa_pkg::status_t                 pend_status_r;
  logic [bfa_pkg::BLK_W-1:0]        out_block_r;
  bfa_pkg::status_t                 out_status_r;

  logic [bfa_pkg::WORDS_W-1:0]      words;
  logic                             issue;
  logic                             ram_we;
  logic [bfa_pkg::WORD_AW-1:0]      ram_waddr;
  logic [bfa_pkg::WORD_BITS-1:0]    ram_wdata;
  logic                             ram_re;
  logic [bfa_pkg::WORD_AW-1:0]      ram_raddr;
  logic [bfa_pkg::WORD_BITS-1:0]    ram_rdata;
  logic [bfa_pkg::WORD_BITS-1:0]    word_eff;
  logic [bfa_pkg::BIT_W-1:0]        zero_bit;
  logic [bfa_pkg::WORD_BITS-1:0]    blk_mask;
  logic                             hit;

  assign words = (total_r >= bfa_pkg::LIMIT_W'(bfa_pkg::MAX_BLOCKS)) ?
                 bfa_pkg::WORDS_W'(bfa_pkg::MAP_WORDS) :
                 bfa_pkg::WORDS_W'(total_r >> bfa_pkg::BIT_W);

  assign issue    = ptr_r < words;
  assign word_eff = valid_r[cur_r] ? ram_rdata : bfa_pkg::reset_word(cur_r);
  assign zero_bit = bfa_pkg::first_zero(word_eff);
  assign hit      = chk_vld_r && !(&word_eff);
  assign blk_mask = bfa_pkg::WORD_BITS'(1) << blk_r[bfa_pkg::BIT_W-1:0];

  assign sts.op         = op_r;
  assign sts.range_bad  = {1'b0, blk_r} >= total_r;
  assign sts.words_zero = (words == '0);
  assign sts.hit        = hit;
  assign sts.scan_end   = !issue && !hit;

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = ptr_r[bfa_pkg::WORD_AW-1:0];
    if (cmd.scan_step) begin
      ram_re = issue;
    end else if (cmd.rmw_read) begin
      ram_re    = 1'b1;
      ram_raddr = blk_r[bfa_pkg::BLK_W-1:bfa_pkg::BIT_W];
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_r;
    ram_wdata = word_eff | (bfa_pkg::WORD_BITS'(1) << zero_bit);
    if (cmd.scan_step && hit) begin
      ram_we = 1'b1;
    end else if (cmd.rmw_write) begin
      ram_we    = 1'b1;
      ram_wdata = (op_r == bfa_pkg::OP_FREE) ? (word_eff & ~blk_mask) :
                                               (word_eff | blk_mask);
    end
  end

  bfa_ram #(
    .WIDTH(bfa_pkg::WORD_BITS),
    .DEPTH(bfa_pkg::MAP_WORDS)
  ) u_map_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= bfa_pkg::TOTAL_RESET;
      valid_r   <= '0;
      chk_vld_r <= 1'b0;
    end else begin
      if (cmd.cfg_we) begin
        total_r <= cfg_total_blocks;
      end
      if (cmd.clear_map) begin
        valid_r <= '0;
      end else if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (cmd.scan_start) begin
        chk_vld_r <= 1'b0;
      end else if (cmd.scan_step) begin
        chk_vld_r <= issue;
      end else if (cmd.rmw_read) begin
        chk_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= bfa_pkg::op_t'(in_command);
      blk_r <= in_block_index;
    end
    if (cmd.scan_start) begin
      ptr_r <= '0;
    end else if (cmd.scan_step && issue) begin
      ptr_r <= ptr_r + bfa_pkg::WORDS_W'(1);
    end
    if (ram_re) begin
      cur_r <= ram_raddr;
    end
    if (cmd.pend_we) begin
      pend_block_r <= blk_r;
      case (cmd.pend_sel)
        bfa_pkg::PS_OK:    pend_status_r <= bfa_pkg::STS_OK;
        bfa_pkg::PS_FULL:  pend_status_r <= bfa_pkg::STS_FULL;
        bfa_pkg::PS_RANGE: pend_status_r <= bfa_pkg::STS_RANGE;
        bfa_pkg::PS_ALLOC: begin
          pend_status_r <= bfa_pkg::STS_OK;
          pend_block_r  <= {cur_r, zero_bit};
        end
        default: pend_status_r <= bfa_pkg::STS_OK;
      endcase
    end
    if (cmd.out_load) begin
      out_block_r  <= pend_block_r;
      out_status_r <= pend_status_r;
    end
  end

  assign out_result_block = out_block_r;
  assign out_status       = out_status_r;

endmodule

// ----- rtl/core/bitmap_first_fit_block_allocator_top.sv -----
// Top level of the bitmap first-fit block allocator.
// Depends on bfa_pkg, bfa_ctrl and bfa_dp (which holds the bfa_ram bitmap).
//
//   Channel  Dir  Handshake          Payload
//   in_      in   in_valid/in_stall  in_command[1:0], in_block_index[11:0]
//   out_     out  out_valid/out_stall out_result_block[11:0], out_status[1:0]
//   cfg_     in   cfg_valid/cfg_ready cfg_total_blocks[12:0]
//
// One command at a time. Format and rejected commands pass through the dispatch
// and finish states to the result register; free and mark-used also read and
// write the bitmap word in between. Allocate scans the words after dispatch, fed
// by the bitmap RAM read port that delivers one 64-bit word per cycle.
// Synchronous active-low reset restores the reset map through per-word valid
// bits, so no clearing pass is needed. A stalled result is held in the output
// register while the next command may already be accepted.
module bitmap_first_fit_block_allocator_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_command,
  input  logic [bfa_pkg::BLK_W-1:0]   in_block_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [bfa_pkg::BLK_W-1:0]   out_result_block,
  output logic [1:0]                  out_status,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bfa_pkg::LIMIT_W-1:0] cfg_total_blocks
);

  bfa_pkg::dp_cmd_t cmd;
  bfa_pkg::dp_sts_t sts;

  bfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  bfa_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_command      (in_command),
    .in_block_index  (in_block_index),
    .cfg_total_blocks(cfg_total_blocks),
    .out_result_block(out_result_block),
    .out_status      (out_status),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

// ----- rtl/core/bfa_chk.sv -----
// Port-level checker for the block allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_first_fit_block_allocator_top.
module bfa_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [bfa_pkg::BLK_W-1:0]   out_result_block,
  input logic [1:0]                  out_status
);

  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status != 2'd3))
    else $error("result beat carries an undefined status code");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled while a command is in progress");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("new result beat appeared while still busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_result_block) && $stable(out_status)))
    else $error("stalled result beat changed");

endmodule

bind bitmap_first_fit_block_allocator_top bfa_chk u_bfa_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_result_block(out_result_block),
  .out_status      (out_status)
);

// ----- test/bitmap_first_fit_block_allocator_top_tb.sv -----
// Self-checking testbench for bitmap_first_fit_block_allocator_top: a directed table,
// then random command phases under several store sizes, checked against a local bitmap.
// Depends on bfa_pkg and the allocator RTL only.
`timescale 1ns / 100ps

module bitmap_first_fit_block_allocator_top_tb;
  import bfa_pkg::*;

  typedef struct {
    logic [BLK_W-1:0] block;
    status_t          status;
  } alloc_reply_t;

  typedef struct {
    op_t              op;
    logic [BLK_W-1:0] idx;
    bit               known;
    logic [BLK_W-1:0] exp_block;
    status_t          exp_status;
  } cmd_row_t;

  localparam int DIR_N   = 19;
  localparam int PHASE_N = 11;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_command = OP_FORMAT;
  logic [BLK_W-1:0]     in_block_index = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [BLK_W-1:0]     out_result_block;
  logic [1:0]           out_status;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LIMIT_W-1:0]   cfg_total_blocks = '0;

  logic [WORD_BITS-1:0] used_map [MAP_WORDS];
  logic [LIMIT_W-1:0]   store_blocks;
  alloc_reply_t         pending_replies[$];
  int                   mismatches = 0;
  int                   replies_seen = 0;
  bit                   no_gaps = 1'b0;

  cmd_row_t directed_rows [DIR_N];
  int unsigned phase_total [PHASE_N] = '{0, 63, 64, 4096, 128, 200, 8191, 320, 4096, 65, 512};
  int          phase_fill  [PHASE_N] = '{0, 0, 66, 0, 130, 194, 0, 322, 0, 0, 0};
  int          phase_rand  [PHASE_N] = '{40, 40, 80, 150, 100, 100, 120, 100, 160, 80, 120};

  bitmap_first_fit_block_allocator_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_block_index   (in_block_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_block (out_result_block),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_total_blocks (cfg_total_blocks)
  );

  always #6 clk = ~clk;

  function automatic int unsigned store_limit();
    return (store_blocks > LIMIT_W'(MAX_BLOCKS)) ? MAX_BLOCKS : store_blocks;
  endfunction

  function automatic void wipe_map();
    foreach (used_map[w]) used_map[w] = '0;
    used_map[0] = 64'h3;
  endfunction

  // Applies one command to the local bitmap and returns the reply it must produce.
  function automatic alloc_reply_t apply_block_cmd(input op_t op, input logic [BLK_W-1:0] idx);
    alloc_reply_t r;
    int unsigned  lim;
    int unsigned  words;
    bit           found;
    lim = store_limit();
    r.block = idx;
    r.status = STS_OK;
    found = 1'b0;
    case (op)
      OP_FORMAT: begin
        wipe_map();
      end
      OP_ALLOC: begin
        words = lim / WORD_BITS;
        for (int w = 0; w < words && !found; w++) begin
          for (int b = 0; b < WORD_BITS && !found; b++) begin
            if (!used_map[w][b]) begin
              used_map[w][b] = 1'b1;
              r.block = BLK_W'(w * WORD_BITS + b);
              found = 1'b1;
            end
          end
        end
        if (!found) r.status = STS_FULL;
      end
      default: begin
        if (idx >= lim) begin
          r.status = STS_RANGE;
        end else begin
          used_map[idx / WORD_BITS][idx % WORD_BITS] = (op == OP_MARK);
        end
      end
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [BLK_W-1:0] pick_block();
    int unsigned lim;
    lim = store_limit();
    if (lim > 0 && $urandom_range(0, 99) < 75) return BLK_W'($urandom_range(0, lim - 1));
    return BLK_W'($urandom_range(0, MAX_BLOCKS - 1));
  endfunction

  // Entered and left on a falling edge; in_valid drops after each beat.
  task automatic send_cmd(input op_t op, input logic [BLK_W-1:0] idx, input bit known,
                          input logic [BLK_W-1:0] exp_block, input status_t exp_status);
    int           gap;
    alloc_reply_t pred;
    alloc_reply_t typed;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_command = op;
    in_block_index = idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = apply_block_cmd(op, idx);
    typed.block = exp_block;
    typed.status = exp_status;
    pending_replies.insert(pending_replies.size(), known ? typed : pred);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain_replies();
    in_valid = 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic write_store_blocks(input logic [LIMIT_W-1:0] value);
    drain_replies();
    cfg_valid = 1'b1;
    cfg_total_blocks = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    store_blocks = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_random_cmd();
    int  r;
    op_t op;
    r = $urandom_range(0, 99);
    if (r < 2) op = OP_FORMAT;
    else if (r < 50) op = OP_ALLOC;
    else if (r < 75) op = OP_FREE;
    else op = OP_MARK;
    send_cmd(op, pick_block(), 1'b0, '0, STS_OK);
  endtask

  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected beat, block %0d status %0d", $time, out_result_block,
                 out_status);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_result_block !== want.block) begin
          $display("%0t: result_block expected %0d, got %0d", $time, want.block,
                   out_result_block);
          mismatches++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, out_status);
          mismatches++;
        end
      end
    end
  end

  // Output back-pressure, with two long holds so that the input side backs up.
  initial begin : result_stall_gen
    int  run_len;
    int  r;
    bit  hold_a_done;
    bit  hold_b_done;
    hold_a_done = 1'b0;
    hold_b_done = 1'b0;
    wait (rst_n);
    forever begin
      if ((!hold_a_done && replies_seen >= 400) || (!hold_b_done && replies_seen >= 1300)) begin
        if (replies_seen >= 1300) hold_b_done = 1'b1;
        hold_a_done = 1'b1;
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
      end
      r = $urandom_range(0, 99);
      run_len = (r < 20) ? $urandom_range(50, 200) : $urandom_range(1, 20);
      out_stall = 1'b0;
      repeat (run_len) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 70) run_len = $urandom_range(1, 2);
      else if (r < 95) run_len = $urandom_range(3, 8);
      else run_len = $urandom_range(20, 60);
      out_stall = 1'b1;
      repeat (run_len) @(negedge clk);
    end
  end

  initial begin : stimulus
    directed_rows = '{
      '{OP_FORMAT, 12'hFFF, 1'b1, 12'hFFF, STS_OK},
      '{OP_ALLOC,  12'h000, 1'b1, 12'h002, STS_OK},
      '{OP_ALLOC,  12'hABC, 1'b1, 12'h003, STS_OK},
      '{OP_FREE,   12'hFFF, 1'b1, 12'hFFF, STS_RANGE},
      '{OP_MARK,   12'h200, 1'b1, 12'h200, STS_RANGE},
      '{OP_FREE,   12'h1FF, 1'b1, 12'h1FF, STS_OK},
      '{OP_MARK,   12'h1FF, 1'b1, 12'h1FF, STS_OK},
      '{OP_FREE,   12'h000, 1'b1, 12'h000, STS_OK},
      '{OP_ALLOC,  12'h555, 1'b1, 12'h000, STS_OK},
      '{OP_FREE,   12'h001, 1'b1, 12'h001, STS_OK},
      '{OP_ALLOC,  12'hAAA, 1'b1, 12'h001, STS_OK},
      '{OP_ALLOC,  12'h000, 1'b0, 12'h000, STS_OK},
      '{OP_MARK,   12'h03F, 1'b0, 12'h000, STS_OK},
      '{OP_FREE,   12'h002, 1'b0, 12'h000, STS_OK},
      '{OP_ALLOC,  12'h7FF, 1'b0, 12'h000, STS_OK},
      '{OP_FORMAT, 12'h555, 1'b1, 12'h555, STS_OK},
      '{OP_ALLOC,  12'hFFF, 1'b1, 12'h002, STS_OK},
      '{OP_FREE,   12'h1FF, 1'b0, 12'h000, STS_OK},
      '{OP_MARK,   12'h0AA, 1'b0, 12'h000, STS_OK}
    };
    store_blocks = TOTAL_RESET;
    wipe_map();
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].known,
               directed_rows[i].exp_block, directed_rows[i].exp_status);
    end
    for (int p = 0; p < PHASE_N; p++) begin
      write_store_blocks(LIMIT_W'(phase_total[p]));
      no_gaps = (p % 3 == 1);
      repeat (phase_fill[p]) send_cmd(OP_ALLOC, pick_block(), 1'b0, '0, STS_OK);
      for (int i = 0; i < phase_rand[p]; i++) begin
        if (p == 3 && i == phase_rand[p] / 2) drain_replies();
        send_random_cmd();
      end
    end
    drain_replies();
    repeat (70) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
